[rtl/core/lzwd_pkg.sv]
// Shared types and constants for the LZSS window decompressor.
package lzwd_pkg;

  // History ring geometry
  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  // Command queue geometry
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CMD_FIFO_AW    = $clog2(CMD_FIFO_DEPTH);

  // Copy length: count low nibble plus this bias
  localparam logic [4:0] COPY_LEN_BIAS = 5'd2;

  // Count byte masks
  localparam logic [7:0] CNT_HI_MASK = 8'hF0;
  localparam logic [7:0] CNT_LO_MASK = 8'h0F;

  // Parser phase; the unused code is handled as awaiting a tag
  typedef enum logic [1:0] {
    PH_TAG    = 2'd0,
    PH_DATA   = 2'd1,
    PH_OFFSET = 2'd2
  } phase_t;

  // Command kinds passed from parser to executor
  typedef enum logic [1:0] {
    CMD_LIT  = 2'd0,
    CMD_EOS  = 2'd1,
    CMD_COPY = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         lit;       // literal byte
    logic [HIST_AW-1:0] distance;  // copy distance
    logic [3:0]         len;       // copy length minus bias
  } cmd_t;

  // Executor state
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_COPY = 1'b1
  } bk_state_t;

endpackage

[rtl/core/lzss_window_decompressor.sv]
// Top level of the LZSS window decompressor.
// Compressed bytes enter one per beat on the in_ channel; decompressed bytes leave one per
// beat on the out_ channel, with out_last_of_run marking the final byte caused by an input
// byte and out_end_of_stream marking the single zero byte sent for a zero count byte. A
// parser takes tag, count and offset bytes and queues literal, end and copy commands four
// deep; an executor drains the queue and emits each literal or end marker directly, and it
// reads a copy of n bytes (2 to 17) byte by byte back out of the history ring, so the
// executor delivers at most one byte per cycle, limited by the single write port of the
// 4096-byte history ring and the one output register. The ring needs no clearing pass
// after reset: a fill mark tracks which entries have been written, and an unwritten entry
// reads as zero, so the block takes input from the first cycle after reset.
module lzss_window_decompressor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_end_of_stream
);

  logic           push;
  lzwd_pkg::cmd_t push_cmd;
  logic           fifo_full;
  logic           fifo_empty;
  logic           pop;
  lzwd_pkg::cmd_t head_cmd;

  // Parse incoming bytes into commands
  lzwd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Decouple parser from executor
  lzwd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (fifo_empty)
  );

  // Execute commands against the history ring
  lzwd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .fifo_empty        (fifo_empty),
    .head_cmd          (head_cmd),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_stream (out_end_of_stream)
  );

endmodule

[rtl/core/lzwd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; read data holds when not enabled
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/lzwd_front.sv]
// Stream parser: splits compressed bytes into literal, end and copy commands.
module lzwd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             fifo_full,
  output logic             push,
  output lzwd_pkg::cmd_t   push_cmd
);

  lzwd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       flag_shift_r, flag_shift_nxt;
  logic [3:0]       flags_left_r, flags_left_nxt;
  logic [7:0]       held_count_r, held_count_nxt;
  logic             accept;
  logic [3:0]       flags_dec;
  logic             flag_bit;

  // Stall whenever the command queue cannot take another entry
  assign in_stall  = fifo_full;
  assign accept    = in_valid && !in_stall;
  assign flags_dec = (flags_left_r == 4'd0) ? 4'd0 : flags_left_r - 4'd1;
  assign flag_bit  = flag_shift_r[7];

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      case (phase_r)
        lzwd_pkg::PH_DATA: begin
          if (!flag_bit) begin
            phase_nxt = (flags_dec == 4'd0) ? lzwd_pkg::PH_TAG : lzwd_pkg::PH_DATA;
          end else if (in_byte == 8'd0) begin
            phase_nxt = lzwd_pkg::PH_TAG;
          end else begin
            phase_nxt = lzwd_pkg::PH_OFFSET;
          end
        end
        lzwd_pkg::PH_OFFSET: begin
          phase_nxt = (flags_left_r == 4'd0) ? lzwd_pkg::PH_TAG : lzwd_pkg::PH_DATA;
        end
        default: begin
          phase_nxt = lzwd_pkg::PH_DATA;
        end
      endcase
    end
  end

  // Flag bookkeeping and command build
  always_comb begin
    flag_shift_nxt    = flag_shift_r;
    flags_left_nxt    = flags_left_r;
    held_count_nxt    = held_count_r;
    push              = 1'b0;
    push_cmd.kind     = lzwd_pkg::CMD_LIT;
    push_cmd.lit      = in_byte;
    push_cmd.distance = {held_count_r[7:4], in_byte};
    push_cmd.len      = held_count_r[3:0];
    if (accept) begin
      case (phase_r)
        lzwd_pkg::PH_DATA: begin
          flag_shift_nxt = {flag_shift_r[6:0], 1'b0};
          flags_left_nxt = flags_dec;
          if (!flag_bit) begin
            push          = 1'b1;
            push_cmd.kind = lzwd_pkg::CMD_LIT;
          end else if (in_byte == 8'd0) begin
            // End marker: drop the unused flags
            flag_shift_nxt = 8'd0;
            flags_left_nxt = 4'd0;
            push           = 1'b1;
            push_cmd.kind  = lzwd_pkg::CMD_EOS;
          end else begin
            held_count_nxt = in_byte;
          end
        end
        lzwd_pkg::PH_OFFSET: begin
          push          = 1'b1;
          push_cmd.kind = lzwd_pkg::CMD_COPY;
        end
        default: begin
          flag_shift_nxt = in_byte;
          flags_left_nxt = 4'd8;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lzwd_pkg::PH_TAG;
      flag_shift_r <= 8'd0;
      flags_left_r <= 4'd0;
      held_count_r <= 8'd0;
    end else begin
      phase_r      <= phase_nxt;
      flag_shift_r <= flag_shift_nxt;
      flags_left_r <= flags_left_nxt;
      held_count_r <= held_count_nxt;
    end
  end

endmodule

[rtl/core/lzwd_cmd_fifo.sv]
// Short command queue between the parser and the executor.
module lzwd_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lzwd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output lzwd_pkg::cmd_t head_cmd,
  output logic           empty
);

  localparam int AW = lzwd_pkg::CMD_FIFO_AW;

  lzwd_pkg::cmd_t entry_r [lzwd_pkg::CMD_FIFO_DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]    count_r, count_nxt;
  logic           do_push, do_pop;

  assign full     = (count_r == (AW+1)'(lzwd_pkg::CMD_FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/core/lzwd_back.sv]
// Command executor: emits literals and end markers, runs copies out of the history ring.
module lzwd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fifo_empty,
  input  lzwd_pkg::cmd_t head_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_last_of_run,
  output logic           out_end_of_stream
);

  localparam int AW = lzwd_pkg::HIST_AW;

  lzwd_pkg::bk_state_t state_r, state_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [4:0]    left_r, left_nxt;
  logic          s2_v_r, s2_v_nxt;
  logic          s2_last_r, s2_last_nxt;
  logic          byp_r, byp_nxt;
  logic          rdv_r, rdv_nxt;
  logic [7:0]    lastw_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_eos_r, out_eos_nxt;

  logic          adv;
  logic          wr_en;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [7:0]    rd_data;
  logic [7:0]    s2_byte;

  // Advance only when the output register is free or being emptied
  assign adv = !out_valid_r || !out_stall;

  // Copy byte: forward the byte just written, or zero for a never-written entry
  assign s2_byte = byp_r ? lastw_r : (rdv_r ? rd_data : 8'd0);

  lzwd_ram #(
    .WIDTH (8),
    .DEPTH (lzwd_pkg::HIST_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (src_r),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lzwd_pkg::BK_IDLE: begin
        if (adv && !fifo_empty && head_cmd.kind == lzwd_pkg::CMD_COPY) begin
          state_nxt = lzwd_pkg::BK_COPY;
        end
      end
      lzwd_pkg::BK_COPY: begin
        if (adv && s2_v_r && s2_last_r) begin
          state_nxt = lzwd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = lzwd_pkg::BK_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    pop           = 1'b0;
    wr_en         = 1'b0;
    wr_data       = s2_byte;
    rd_en         = 1'b0;
    src_nxt       = src_r;
    left_nxt      = left_r;
    s2_v_nxt      = s2_v_r;
    s2_last_nxt   = s2_last_r;
    byp_nxt       = byp_r;
    rdv_nxt       = rdv_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_eos_nxt   = out_eos_r;
    if (adv) begin
      case (state_r)
        lzwd_pkg::BK_IDLE: begin
          if (!fifo_empty) begin
            pop = 1'b1;
            case (head_cmd.kind)
              lzwd_pkg::CMD_LIT: begin
                wr_en         = 1'b1;
                wr_data       = head_cmd.lit;
                out_valid_nxt = 1'b1;
                out_byte_nxt  = head_cmd.lit;
                out_last_nxt  = 1'b1;
                out_eos_nxt   = 1'b0;
              end
              lzwd_pkg::CMD_EOS: begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = 8'd0;
                out_last_nxt  = 1'b1;
                out_eos_nxt   = 1'b1;
              end
              lzwd_pkg::CMD_COPY: begin
                src_nxt  = wp_r - head_cmd.distance;
                left_nxt = {1'b0, head_cmd.len} + lzwd_pkg::COPY_LEN_BIAS;
                s2_v_nxt = 1'b0;
              end
              default: begin
                out_valid_nxt = 1'b0;
              end
            endcase
          end
        end
        lzwd_pkg::BK_COPY: begin
          // Retire the byte from the last source read
          s2_v_nxt = 1'b0;
          if (s2_v_r) begin
            wr_en         = 1'b1;
            wr_data       = s2_byte;
            out_valid_nxt = 1'b1;
            out_byte_nxt  = s2_byte;
            out_last_nxt  = s2_last_r;
            out_eos_nxt   = 1'b0;
          end
          // Issue the next source read
          if (left_r != 5'd0) begin
            rd_en       = 1'b1;
            src_nxt     = src_r + AW'(1);
            left_nxt    = left_r - 5'd1;
            s2_v_nxt    = 1'b1;
            s2_last_nxt = (left_r == 5'd1);
            byp_nxt     = s2_v_r && (src_r == wp_r);
            rdv_nxt     = wrapped_r || (src_r < wp_r);
          end
        end
        default: begin
          s2_v_nxt = 1'b0;
        end
      endcase
    end
  end

  // Ring write pointer and wrap mark
  always_comb begin
    wp_nxt      = wr_en ? wp_r + AW'(1) : wp_r;
    wrapped_nxt = wrapped_r || (wr_en && (wp_r == '1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzwd_pkg::BK_IDLE;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      left_r      <= 5'd0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      left_r      <= left_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    s2_last_r  <= s2_last_nxt;
    byp_r      <= byp_nxt;
    rdv_r      <= rdv_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_eos_r  <= out_eos_nxt;
    if (wr_en) begin
      lastw_r <= wr_data;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_of_run   = out_last_r;
  assign out_end_of_stream = out_eos_r;

endmodule
